// ===== src/b64d_pkg.sv =====
package b64d_pkg;

    localparam int CHAR_W  = 8;
    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 16;
    localparam int SEXT_W  = 6;

    // longest encoded string the byte counter is sized for
    localparam longint unsigned MAX_INPUT_CHARS = 1048576 / 16;
    localparam longint unsigned LIMIT_RAW       = (MAX_INPUT_CHARS * 3) / 4;
    localparam logic [COUNT_W-1:0] COUNT_LIMIT  =
        (LIMIT_RAW > 64'd65535) ? 16'hFFFF : COUNT_W'(LIMIT_RAW);

    localparam logic [CHAR_W-1:0] CHAR_PAD   = 8'h3D;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_SLASH = 8'h2F;

    typedef struct packed {
        logic [BYTE_W-1:0]  data_byte;
        logic               byte_valid;
        logic               last;
        logic [COUNT_W-1:0] total_count;
    } t_result;

    // bit 6 set: not part of the alphabet
    function automatic logic [SEXT_W:0] sextet_of(input logic [CHAR_W-1:0] c);
        logic [SEXT_W:0] s;
        s = 7'h40;
        if (c >= 8'h41 && c <= 8'h5A) begin
            s = 7'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            s = 7'(c - 8'h61 + 8'd26);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            s = 7'(c - 8'h30 + 8'd52);
        end else if (c == CHAR_PLUS) begin
            s = 7'd62;
        end else if (c == CHAR_SLASH) begin
            s = 7'd63;
        end
        return s;
    endfunction

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] t,
                                                   input logic v);
        return (v && (t < COUNT_LIMIT)) ? COUNT_W'(t + 16'd1) : t;
    endfunction

endpackage

// ===== src/b64d_if.sv =====
interface b64d_in_if import b64d_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] in_char;
    logic              end_of_input;

    modport source (output valid, output in_char, output end_of_input, input ready);
    modport sink   (input valid, input in_char, input end_of_input, output ready);
endinterface

interface b64d_out_if import b64d_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [BYTE_W-1:0]  data_byte;
    logic               byte_valid;
    logic               last;
    logic [COUNT_W-1:0] total_count;

    modport source (output valid, output data_byte, output byte_valid, output last,
                    output total_count, input ready);
    modport sink   (input valid, input data_byte, input byte_valid, input last,
                    input total_count, output ready);
endinterface

// ===== src/base64_stream_decoder.sv =====
// channel   dir  payload                                          item
// i_in      in   in_char[7:0], end_of_input                       one character
// o_out     out  data_byte[7:0], byte_valid, last, total_count    one decoded byte or end marker
//
// one character is taken per cycle while i_in.ready is high; it is registered,
// decoded in the next cycle and its zero to three results are written into an
// 8-entry result queue; the queue drives o_out directly
// i_in.ready drops only while the queue, counted with the results of the
// registered item, would hold more than five items, so a stalled o_out backs
// up into i_in and nothing is lost
// i_rst_n is synchronous, active low, and clears the decoder state and queue
module base64_stream_decoder
    import b64d_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    b64d_in_if.sink    i_in,
    b64d_out_if.source o_out
);

    localparam int QDEPTH = 8;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = QPTR_W + 1;
    // room left for the three results the new item may push next cycle
    localparam logic [QCNT_W-1:0] ACCEPT_MAX = QCNT_W'(QDEPTH - 3);

    // input register
    logic              r_in_valid;
    logic [CHAR_W-1:0] r_in_char;
    logic              r_in_end;

    // decoder state
    logic [SEXT_W-1:0]  r_sext [3];
    logic [1:0]         r_scount;
    logic               r_pad;
    logic [COUNT_W-1:0] r_total;

    logic [SEXT_W-1:0]  n_sext [3];
    logic [1:0]         n_scount;
    logic               n_pad;
    logic [COUNT_W-1:0] n_total;

    // results of the registered item, in order
    t_result    res [3];
    logic [1:0] npush;

    // result queue
    t_result           r_queue [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_qcnt;

    logic            in_accept;
    logic            out_pop;
    logic [SEXT_W:0] sx;

    assign i_in.ready = (QCNT_W'(r_qcnt + QCNT_W'(npush)) <= ACCEPT_MAX);
    assign in_accept  = i_in.valid && i_in.ready;
    assign out_pop    = o_out.valid && o_out.ready;

    assign o_out.valid       = (r_qcnt != '0);
    assign o_out.data_byte   = r_queue[r_rd_ptr].data_byte;
    assign o_out.byte_valid  = r_queue[r_rd_ptr].byte_valid;
    assign o_out.last        = r_queue[r_rd_ptr].last;
    assign o_out.total_count = r_queue[r_rd_ptr].total_count;

    assign sx = sextet_of(r_in_char);

    // decode of the registered character
    always_comb begin
        logic [1:0]         lidx;
        logic [COUNT_W-1:0] t0;
        logic [COUNT_W-1:0] t1;
        logic [COUNT_W-1:0] t2;
        n_sext   = r_sext;
        n_scount = r_scount;
        n_pad    = r_pad;
        npush    = 2'd0;
        lidx     = 2'd0;
        for (int k = 0; k < 3; k++) begin
            res[k] = '0;
        end

        if (r_in_valid && !r_pad) begin
            if (r_in_char == CHAR_PAD) begin
                n_pad = 1'b1;
            end else if (!sx[SEXT_W]) begin
                if (r_scount == 2'd3) begin
                    // fourth sextet completes a group: three bytes
                    res[0].data_byte  = {r_sext[0], r_sext[1][5:4]};
                    res[1].data_byte  = {r_sext[1][3:0], r_sext[2][5:2]};
                    res[2].data_byte  = {r_sext[2][1:0], sx[SEXT_W-1:0]};
                    res[0].byte_valid = 1'b1;
                    res[1].byte_valid = 1'b1;
                    res[2].byte_valid = 1'b1;
                    npush             = 2'd3;
                    n_scount          = 2'd0;
                end else begin
                    n_sext[r_scount] = sx[SEXT_W-1:0];
                    n_scount         = 2'(r_scount + 2'd1);
                end
            end
        end

        if (r_in_valid && r_in_end) begin
            if (npush == 2'd0) begin
                case (n_scount)
                    2'd2: begin
                        res[0].data_byte  = {n_sext[0], n_sext[1][5:4]};
                        res[0].byte_valid = 1'b1;
                        npush             = 2'd1;
                    end
                    2'd3: begin
                        res[0].data_byte  = {n_sext[0], n_sext[1][5:4]};
                        res[1].data_byte  = {n_sext[1][3:0], n_sext[2][5:2]};
                        res[0].byte_valid = 1'b1;
                        res[1].byte_valid = 1'b1;
                        npush             = 2'd2;
                    end
                    default: begin
                        // empty end marker
                        npush = 2'd1;
                    end
                endcase
            end
            lidx = 2'(npush - 2'd1);
            res[lidx].last = 1'b1;
        end

        // running byte count, saturating per byte
        t0 = sat_inc(r_total, res[0].byte_valid);
        t1 = sat_inc(t0, res[1].byte_valid);
        t2 = sat_inc(t1, res[2].byte_valid);
        res[0].total_count = t0;
        res[1].total_count = t1;
        res[2].total_count = t2;
        n_total = r_in_valid ? t2 : r_total;

        // end of string: back to the reset state
        if (r_in_valid && r_in_end) begin
            for (int k = 0; k < 3; k++) begin
                n_sext[k] = '0;
            end
            n_scount = 2'd0;
            n_pad    = 1'b0;
            n_total  = '0;
        end
    end

    // input register and decoder state
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_char <= i_in.in_char;
            r_in_end  <= i_in.end_of_input;
        end
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                r_sext[k] <= '0;
            end
            r_scount <= 2'd0;
            r_pad    <= 1'b0;
            r_total  <= '0;
        end else begin
            r_in_valid <= in_accept;
            r_sext     <= n_sext;
            r_scount   <= n_scount;
            r_pad      <= n_pad;
            r_total    <= n_total;
        end
    end

    // result queue storage, up to three writes per cycle
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            if (2'(k) < npush) begin
                r_queue[QPTR_W'(r_wr_ptr + QPTR_W'(k))] <= res[k];
            end
        end
    end

    // queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_qcnt   <= '0;
        end else begin
            r_wr_ptr <= QPTR_W'(r_wr_ptr + QPTR_W'(npush));
            r_rd_ptr <= QPTR_W'(r_rd_ptr + QPTR_W'(out_pop));
            r_qcnt   <= QCNT_W'(r_qcnt + QCNT_W'(npush) - QCNT_W'(out_pop));
        end
    end

endmodule
